/* hdl/order_book_ask_bid_matcher_defines.svh */
// Assertion macros used by the order book matcher top level.
`ifndef ORDER_BOOK_ASK_BID_MATCHER_DEFINES_SVH
`define ORDER_BOOK_ASK_BID_MATCHER_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define OBM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The antecedent implies the consequent at the same clock edge.
`define OBM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hdl/obm_pkg.sv */
// Types, constants and codes shared by the order book matcher modules.
package obm_pkg;

   localparam int BOOK_DEPTH = 16;
   localparam int IDX_W      = $clog2(BOOK_DEPTH);
   localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
   localparam int PRODUCT_W  = 8;
   localparam int TIME_W     = 32;
   localparam int PRICE_W    = 32;
   localparam int QTY_W      = 32;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_MATCH  = 1'b1;
   localparam logic SIDE_ASK      = 1'b0;
   localparam logic SIDE_BID      = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             insert;
      logic             start_match;
      logic             scan_feed;
      logic [IDX_W-1:0] scan_addr;
      logic             step_pop_bid;
      logic             step_sale;
      logic             finish;
   } obm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CNT_W-1:0] entry_count;
      logic             ask_valid;
      logic             bid_valid;
      logic             bid_empty;
      logic             price_short;
      logic             out_free;
      logic             pend_free;
   } obm_sts_type;

endpackage

/* hdl/obm_sorter.sv */
// Price-sorted list of order copies with insertion at the sorted place, pop and update at the head.
module obm_sorter
   import obm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               descending,
   input  logic               clear,
   input  logic               push,
   input  logic [PRICE_W-1:0] push_price,
   input  logic [QTY_W-1:0]   push_qty,
   input  logic               push_sim,
   input  logic               pop,
   input  logic               update,
   input  logic [QTY_W-1:0]   update_rem,
   output logic               head_valid,
   output logic [PRICE_W-1:0] head_price,
   output logic [QTY_W-1:0]   head_rem,
   output logic               head_sim
);

   logic               valid_ff [BOOK_DEPTH];
   logic [PRICE_W-1:0] price_ff [BOOK_DEPTH];
   logic [QTY_W-1:0]   rem_ff   [BOOK_DEPTH];
   logic               sim_ff   [BOOK_DEPTH];
   logic               ins_here [BOOK_DEPTH];

   // A new key goes before the first cell that must follow it; equal prices stay ahead.
   always_comb begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
         ins_here[i] = !valid_ff[i] ||
                       (descending ? (price_ff[i] < push_price) : (price_ff[i] > push_price));
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < BOOK_DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (push) begin
         for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (i > 0 && ins_here[i-1]) valid_ff[i] <= valid_ff[i-1];
            else if (ins_here[i])       valid_ff[i] <= 1'b1;
         end
      end else if (pop) begin
         for (int i = 0; i < BOOK_DEPTH - 1; i++) valid_ff[i] <= valid_ff[i+1];
         valid_ff[BOOK_DEPTH-1] <= 1'b0;
      end
   end

   // Cell contents.
   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (i > 0 && ins_here[i-1]) begin
               price_ff[i] <= price_ff[i-1];
               rem_ff[i]   <= rem_ff[i-1];
               sim_ff[i]   <= sim_ff[i-1];
            end else if (ins_here[i]) begin
               price_ff[i] <= push_price;
               rem_ff[i]   <= push_qty;
               sim_ff[i]   <= push_sim;
            end
         end
      end else if (pop) begin
         for (int i = 0; i < BOOK_DEPTH - 1; i++) begin
            price_ff[i] <= price_ff[i+1];
            rem_ff[i]   <= rem_ff[i+1];
            sim_ff[i]   <= sim_ff[i+1];
         end
      end else if (update) begin
         rem_ff[0] <= update_rem;
      end
   end

   assign head_valid = valid_ff[0];
   assign head_price = price_ff[0];
   assign head_rem   = rem_ff[0];
   assign head_sim   = sim_ff[0];

endmodule

/* hdl/obm_dp.sv */
// Datapath: order table, ask and bid lists, pending sale and output register.
module obm_dp
   import obm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  obm_cmd_type          cmd,
   output obm_sts_type          sts,
   input  logic                 req_order_kind,
   input  logic [PRODUCT_W-1:0] req_product_id,
   input  logic [TIME_W-1:0]    req_time_slot,
   input  logic [PRICE_W-1:0]   req_price,
   input  logic [QTY_W-1:0]     req_quantity,
   input  logic                 req_by_sim_user,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic                 rsp_is_sale,
   output logic                 rsp_status,
   output logic [PRICE_W-1:0]   rsp_sale_price,
   output logic [QTY_W-1:0]     rsp_sale_quantity,
   output logic                 rsp_sale_side,
   output logic                 rsp_sale_by_sim,
   output logic [PRODUCT_W-1:0] rsp_sale_product,
   output logic [TIME_W-1:0]    rsp_sale_time,
   output logic                 rsp_last
);

   // Order table, kept in time order.
   logic [CNT_W-1:0]     count_ff;
   logic                 tbl_side_ff    [BOOK_DEPTH];
   logic [PRODUCT_W-1:0] tbl_product_ff [BOOK_DEPTH];
   logic [TIME_W-1:0]    tbl_time_ff    [BOOK_DEPTH];
   logic [PRICE_W-1:0]   tbl_price_ff   [BOOK_DEPTH];
   logic [QTY_W-1:0]     tbl_qty_ff     [BOOK_DEPTH];
   logic                 tbl_sim_ff     [BOOK_DEPTH];
   logic                 ins_here       [BOOK_DEPTH];
   logic                 table_full;

   // Match request.
   logic [PRODUCT_W-1:0] match_prod_ff;
   logic [TIME_W-1:0]    match_time_ff;

   // List heads and the pairing step.
   logic               ask_valid, bid_valid, ask_sim, bid_sim;
   logic [PRICE_W-1:0] ask_price, bid_price;
   logic [QTY_W-1:0]   ask_rem, bid_rem, sale_qty;
   logic               bid_covers, sel_entry, push_ask, push_bid;
   logic               ask_pop, bid_pop;

   // Pending sale and output register.
   logic               pend_valid_ff;
   logic [PRICE_W-1:0] pend_price_ff;
   logic [QTY_W-1:0]   pend_qty_ff;
   logic               pend_side_ff, pend_sim_ff;
   logic               out_valid_ff;
   logic               out_free;

   assign table_full = (count_ff == CNT_W'(BOOK_DEPTH));

   // The new order goes after every stored order with an equal or earlier time.
   always_comb begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
         ins_here[i] = (CNT_W'(i) <= count_ff) &&
                       ((CNT_W'(i) == count_ff) || (tbl_time_ff[i] > req_time_slot));
      end
   end

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.insert && !table_full) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Table contents: entries after the insertion point move up by one.
   always_ff @(posedge clock) begin
      if (cmd.insert && !table_full) begin
         for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (i > 0 && ins_here[i-1]) begin
               tbl_side_ff[i]    <= tbl_side_ff[i-1];
               tbl_product_ff[i] <= tbl_product_ff[i-1];
               tbl_time_ff[i]    <= tbl_time_ff[i-1];
               tbl_price_ff[i]   <= tbl_price_ff[i-1];
               tbl_qty_ff[i]     <= tbl_qty_ff[i-1];
               tbl_sim_ff[i]     <= tbl_sim_ff[i-1];
            end else if (ins_here[i]) begin
               tbl_side_ff[i]    <= req_order_kind;
               tbl_product_ff[i] <= req_product_id;
               tbl_time_ff[i]    <= req_time_slot;
               tbl_price_ff[i]   <= req_price;
               tbl_qty_ff[i]     <= req_quantity;
               tbl_sim_ff[i]     <= req_by_sim_user;
            end
         end
      end
   end

   // Latch the match request.
   always_ff @(posedge clock) begin
      if (cmd.start_match) begin
         match_prod_ff <= req_product_id;
         match_time_ff <= req_time_slot;
      end
   end

   // Scan one table entry per cycle into the ask or the bid list.
   assign sel_entry = (tbl_product_ff[cmd.scan_addr] == match_prod_ff) &&
                      ((match_time_ff == '0) || (tbl_time_ff[cmd.scan_addr] == match_time_ff));
   assign push_ask  = cmd.scan_feed && sel_entry && (tbl_side_ff[cmd.scan_addr] == SIDE_ASK);
   assign push_bid  = cmd.scan_feed && sel_entry && (tbl_side_ff[cmd.scan_addr] == SIDE_BID);

   // Pairing step: the sale takes the smaller of the two remaining amounts.
   assign bid_covers = (bid_rem >= ask_rem);
   assign sale_qty   = bid_covers ? ask_rem : bid_rem;
   assign ask_pop    = cmd.step_sale && bid_covers;
   assign bid_pop    = cmd.step_pop_bid || (cmd.step_sale && !bid_covers);

   obm_sorter u_asks (
      .clock      (clock),
      .reset      (reset),
      .descending (1'b0),
      .clear      (cmd.start_match),
      .push       (push_ask),
      .push_price (tbl_price_ff[cmd.scan_addr]),
      .push_qty   (tbl_qty_ff[cmd.scan_addr]),
      .push_sim   (tbl_sim_ff[cmd.scan_addr]),
      .pop        (ask_pop),
      .update     (cmd.step_sale && !bid_covers),
      .update_rem (ask_rem - bid_rem),
      .head_valid (ask_valid),
      .head_price (ask_price),
      .head_rem   (ask_rem),
      .head_sim   (ask_sim)
   );

   obm_sorter u_bids (
      .clock      (clock),
      .reset      (reset),
      .descending (1'b1),
      .clear      (cmd.start_match),
      .push       (push_bid),
      .push_price (tbl_price_ff[cmd.scan_addr]),
      .push_qty   (tbl_qty_ff[cmd.scan_addr]),
      .push_sim   (tbl_sim_ff[cmd.scan_addr]),
      .pop        (bid_pop),
      .update     (cmd.step_sale && bid_covers),
      .update_rem (bid_rem - ask_rem),
      .head_valid (bid_valid),
      .head_price (bid_price),
      .head_rem   (bid_rem),
      .head_sim   (bid_sim)
   );

   assign out_free = !out_valid_ff || rsp_tready;

   // Pending and output valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.step_sale)   pend_valid_ff <= 1'b1;
         else if (cmd.finish) pend_valid_ff <= 1'b0;
         if (cmd.insert || cmd.finish || (cmd.step_sale && pend_valid_ff)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // A sale waits in the pending register until the next one shows whether it is the last.
   always_ff @(posedge clock) begin
      if (cmd.step_sale) begin
         pend_price_ff <= ask_price;
         pend_qty_ff   <= sale_qty;
         pend_side_ff  <= ask_sim ? SIDE_ASK : (bid_sim ? SIDE_BID : SIDE_ASK);
         pend_sim_ff   <= ask_sim || bid_sim;
      end
      if (cmd.insert || (cmd.finish && !pend_valid_ff)) begin
         rsp_is_sale       <= 1'b0;
         rsp_status        <= (cmd.insert && table_full) ? STATUS_FULL : STATUS_OK;
         rsp_sale_price    <= '0;
         rsp_sale_quantity <= '0;
         rsp_sale_side     <= SIDE_ASK;
         rsp_sale_by_sim   <= 1'b0;
         rsp_sale_product  <= '0;
         rsp_sale_time     <= '0;
         rsp_last          <= 1'b1;
      end else if (cmd.finish || (cmd.step_sale && pend_valid_ff)) begin
         rsp_is_sale       <= 1'b1;
         rsp_status        <= STATUS_OK;
         rsp_sale_price    <= pend_price_ff;
         rsp_sale_quantity <= pend_qty_ff;
         rsp_sale_side     <= pend_side_ff;
         rsp_sale_by_sim   <= pend_sim_ff;
         rsp_sale_product  <= match_prod_ff;
         rsp_sale_time     <= match_time_ff;
         rsp_last          <= cmd.finish;
      end
   end

   assign rsp_tvalid      = out_valid_ff;
   assign sts.entry_count = count_ff;
   assign sts.ask_valid   = ask_valid;
   assign sts.bid_valid   = bid_valid;
   assign sts.bid_empty   = (bid_rem == '0);
   assign sts.price_short = (bid_price < ask_price);
   assign sts.out_free    = out_free;
   assign sts.pend_free   = !pend_valid_ff || out_free;

endmodule

/* hdl/obm_ctrl.sv */
// Controller: sequences inserts, the table scan and the ask-bid walk.
module obm_ctrl
   import obm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_action,
   input  obm_sts_type sts,
   output logic        req_tready,
   output obm_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = sts.out_free;
            if (req_tvalid && sts.out_free) begin
               if (req_action == ACTION_INSERT) begin
                  cmd.insert = 1'b1;
               end else begin
                  cmd.start_match = 1'b1;
                  scan_in         = '0;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_addr = scan_ff[IDX_W-1:0];
            if (scan_ff == sts.entry_count) begin
               state_in = ST_WALK;
            end else begin
               cmd.scan_feed = 1'b1;
               scan_in       = scan_ff + 1'b1;
            end
         end
         ST_WALK: begin
            if (!sts.ask_valid || !sts.bid_valid) begin
               state_in = ST_FINISH;
            end else if (sts.bid_empty) begin
               cmd.step_pop_bid = 1'b1;
            end else if (sts.price_short) begin
               state_in = ST_FINISH;
            end else if (sts.pend_free) begin
               cmd.step_sale = 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

endmodule

/* hdl/order_book_ask_bid_matcher.sv */
// Order book ask/bid matcher top level: stream ports, controller and datapath.
// The block holds up to BOOK_DEPTH orders in time order and handles one
// transaction at a time. An insert gives one status transaction. In a match,
// the n stored orders are scanned into the price-sorted ask and bid lists,
// one per cycle. Then come w pairing steps until the walk ends. Every step
// retires one order copy, so w is at most n. Finally the finish state moves
// the final result transaction into the output register. Each sale waits in
// a pending register until the next sale or the finish shows whether it is
// the last. A stalled result side holds the walk. The next request is taken
// once the controller is idle and the output register is empty or draining.
`include "order_book_ask_bid_matcher_defines.svh"

module order_book_ask_bid_matcher
   import obm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // product_id[7:0], time_slot[39:8], price[71:40], quantity[103:72],
   // by_sim_user[104], zero fill[111:105]
   input  logic [111:0] req_tdata,
   // action[0], order_kind[1]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[0], sale_price[32:1], sale_quantity[64:33], sale_side[65],
   // sale_by_sim[66], sale_product[74:67], sale_time[106:75], zero fill[111:107]
   output logic [111:0] rsp_tdata,
   // is_sale[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   obm_cmd_type          cmd;
   obm_sts_type          sts;
   logic                 rsp_status, rsp_sale_side, rsp_sale_by_sim;
   logic [PRICE_W-1:0]   rsp_sale_price;
   logic [QTY_W-1:0]     rsp_sale_quantity;
   logic [PRODUCT_W-1:0] rsp_sale_product;
   logic [TIME_W-1:0]    rsp_sale_time;

   obm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser[0]),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   obm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_order_kind    (req_tuser[1]),
      .req_product_id    (req_tdata[7:0]),
      .req_time_slot     (req_tdata[39:8]),
      .req_price         (req_tdata[71:40]),
      .req_quantity      (req_tdata[103:72]),
      .req_by_sim_user   (req_tdata[104]),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_is_sale       (rsp_tuser),
      .rsp_status        (rsp_status),
      .rsp_sale_price    (rsp_sale_price),
      .rsp_sale_quantity (rsp_sale_quantity),
      .rsp_sale_side     (rsp_sale_side),
      .rsp_sale_by_sim   (rsp_sale_by_sim),
      .rsp_sale_product  (rsp_sale_product),
      .rsp_sale_time     (rsp_sale_time),
      .rsp_last          (rsp_tlast)
   );

   // Pack the result transaction.
   assign rsp_tdata = {5'b0, rsp_sale_time, rsp_sale_product, rsp_sale_by_sim,
                       rsp_sale_side, rsp_sale_quantity, rsp_sale_price, rsp_status};

   // Checks on the controller and datapath.
   `OBM_ASSERT_ALWAYS(a_count_bound, sts.entry_count <= CNT_W'(BOOK_DEPTH), "entry count overflow")
   `OBM_ASSERT_IMPLY(a_req_room, req_tvalid && req_tready, !rsp_tvalid || rsp_tready, "request taken while output blocked")
   `OBM_ASSERT_IMPLY(a_count_change, !$past(reset) && (sts.entry_count != $past(sts.entry_count)), $past(cmd.insert), "entry count changed without insert")
   `OBM_ASSERT_IMPLY(a_sale_heads, cmd.step_sale, sts.ask_valid && sts.bid_valid && !sts.bid_empty, "sale without ask and bid")

endmodule
